/* src/smt_pkg.sv */
// Package for the sorted multiset table: request codes, status codes,
// internal operation and sequencer state types. No dependencies.
`default_nettype none
package smt_pkg;

	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int OUT_CNT_W = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_COUNT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_MODIFY = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_DELETE,
		OP_COUNT,
		OP_CLEAR,
		OP_MODIFY,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_EXEC,
		BS_RECMP,
		BS_REINS
	} bstate_t;

endpackage
`default_nettype wire

/* src/sorted_multiset_table_unit.sv */
// Top level of the sorted multiset table: front end, request queue, back end.
// Depends on smt_pkg, smt_front, smt_fifo and smt_back.
//
// Usage:
//   Requests enter on start/busy: a request is taken at a rising edge where
//   start is high and busy is low. action selects insert, delete, count,
//   clear or modify; value and new_value are signed keys.
//   Each request gives one result on status, match_count and size, marked by
//   done for exactly one cycle. The receiver cannot stall; results are never
//   held back.
//   A two-entry queue sits between the front end and the table; busy is high
//   while the queue is full.
//   done is registered after the shift stage, which follows the compare
//   stage. Each request passes through the table sequencer as a compare
//   step, which checks the key against every cell in parallel, then a shift
//   step, which moves the cell row. A modify that finds its old value
//   compares and shifts twice.
//   Reset empties the table and the queue at once; no clearing pass is needed.
`default_nettype none
module sorted_multiset_table_unit import smt_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [ACTION_W-1:0]   action,
	input  wire logic signed [31:0]    value,
	input  wire logic signed [31:0]    new_value,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic [OUT_CNT_W-1:0]       match_count,
	output logic [OUT_CNT_W-1:0]       size
);

	localparam int QW = $bits(op_t) + 2 * VALUE_BITS;

	op_t                   f_op;
	logic [VALUE_BITS-1:0] f_key, f_new_key;
	logic [QW-1:0]         q_wdata, q_rdata;
	logic                  q_push, q_pop, q_full, q_empty;
	op_t                   h_op;
	logic [VALUE_BITS-1:0] h_key, h_new_key;

	smt_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.action    (action),
		.value     (value),
		.new_value (new_value),
		.op        (f_op),
		.key       (f_key),
		.new_key   (f_new_key)
	);

	assign busy    = q_full;
	assign q_push  = start && !q_full;
	assign q_wdata = {f_op, f_key, f_new_key};

	smt_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	assign h_op      = op_t'(q_rdata[QW-1 -: $bits(op_t)]);
	assign h_key     = q_rdata[2*VALUE_BITS-1 -: VALUE_BITS];
	assign h_new_key = q_rdata[VALUE_BITS-1:0];

	smt_back #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.h_op        (h_op),
		.h_key       (h_key),
		.h_new_key   (h_new_key),
		.done        (done),
		.status      (status),
		.match_count (match_count),
		.size        (size)
	);

endmodule
`default_nettype wire

/* src/smt_front.sv */
// Request front end: decodes the action code and maps values to order keys.
// Depends on smt_pkg.
`default_nettype none
module smt_front import smt_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic [ACTION_W-1:0]   action,
	input  wire logic signed [31:0]    value,
	input  wire logic signed [31:0]    new_value,
	output op_t                        op,
	output logic [VALUE_BITS-1:0]      key,
	output logic [VALUE_BITS-1:0]      new_key
);

	logic signed [VALUE_BITS-1:0] val_ext;
	logic signed [VALUE_BITS-1:0] new_ext;

	always_comb begin
		case (action)
			ACT_INSERT: op = OP_INSERT;
			ACT_DELETE: op = OP_DELETE;
			ACT_COUNT:  op = OP_COUNT;
			ACT_CLEAR:  op = OP_CLEAR;
			ACT_MODIFY: op = OP_MODIFY;
			default:    op = OP_NONE;
		endcase
	end

	// flip the sign bit so unsigned order matches signed order
	assign val_ext = VALUE_BITS'(value);
	assign new_ext = VALUE_BITS'(new_value);
	assign key     = {~val_ext[VALUE_BITS-1], val_ext[VALUE_BITS-2:0]};
	assign new_key = {~new_ext[VALUE_BITS-1], new_ext[VALUE_BITS-2:0]};

endmodule
`default_nettype wire

/* src/smt_fifo.sv */
// Small request queue between the front end and the table sequencer.
// No dependencies.
`default_nettype none
module smt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;

	assign full  = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

/* src/smt_back.sv */
// Table back end: row of ordered cells with parallel compare and shift,
// plus the sequencer that carries out each request. Depends on smt_pkg.
`default_nettype none
module smt_back import smt_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	output logic                       q_pop,
	input  wire op_t                   h_op,
	input  wire logic [VALUE_BITS-1:0] h_key,
	input  wire logic [VALUE_BITS-1:0] h_new_key,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic [OUT_CNT_W-1:0]       match_count,
	output logic [OUT_CNT_W-1:0]       size
);

	localparam int CW = $clog2(CAPACITY + 1);

	bstate_t state_q, state_nx;

	op_t                    op_q;
	logic [VALUE_BITS-1:0]  key_q;
	logic [VALUE_BITS-1:0]  new_key_q;
	logic [VALUE_BITS-1:0]  cells_q [CAPACITY];
	logic [CAPACITY-1:0]    lt_s1, le_s1;
	logic [CAPACITY-1:0]    lt_d, le_d;
	logic [CW-1:0]          cnt_q, cnt_nx;
	logic [CW-1:0]          match_q;
	logic [CW-1:0]          p_lt, p_le, eq_cnt;
	logic [VALUE_BITS-1:0]  cmp_key, ins_key;
	logic                   load_cmp, found;
	logic                   do_ins, do_del, do_clr, mod_go;
	logic                   res_vld;
	logic [STATUS_W-1:0]    res_status;
	logic [CW-1:0]          res_match;
	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [CW-1:0]          match_out_q;

	function automatic logic [CW-1:0] therm_count(input logic [CAPACITY-1:0] t);
		logic [CAPACITY-1:0] edg;
		logic [CW-1:0]       n;
		n   = '0;
		edg = t & ~(t >> 1);
		for (int i = 0; i < CAPACITY; i++) begin
			if (edg[i]) begin
				n = n | CW'(i + 1);
			end
		end
		return n;
	endfunction

	assign cmp_key = (state_q == BS_RECMP) ? new_key_q : h_key;
	assign ins_key = (state_q == BS_REINS) ? new_key_q : key_q;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_d[i] = (CW'(i) < cnt_q) && (cells_q[i] <  cmp_key);
			le_d[i] = (CW'(i) < cnt_q) && (cells_q[i] <= cmp_key);
		end
	end

	assign p_lt    = therm_count(lt_s1);
	assign p_le    = therm_count(le_s1);
	assign found   = (p_le != p_lt);
	assign eq_cnt  = p_le - p_lt;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BS_IDLE: begin
				if (!q_empty) begin
					state_nx = BS_EXEC;
				end
			end
			BS_EXEC:  state_nx = mod_go ? BS_RECMP : BS_IDLE;
			BS_RECMP: state_nx = BS_REINS;
			BS_REINS: state_nx = BS_IDLE;
			default:  state_nx = BS_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		load_cmp   = 1'b0;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		do_clr     = 1'b0;
		mod_go     = 1'b0;
		res_vld    = 1'b0;
		res_status = ST_OK;
		res_match  = '0;
		case (state_q)
			BS_IDLE: begin
				q_pop    = !q_empty;
				load_cmp = !q_empty;
			end
			BS_EXEC: begin
				res_vld = 1'b1;
				case (op_q)
					OP_INSERT: begin
						if (cnt_q == CW'(CAPACITY)) begin
							res_status = ST_FULL;
						end else begin
							do_ins = 1'b1;
						end
					end
					OP_DELETE: begin
						if (cnt_q == '0) begin
							res_status = ST_EMPTY;
						end else if (found) begin
							do_del = 1'b1;
						end else begin
							res_status = ST_NOT_FOUND;
						end
					end
					OP_COUNT: res_match = eq_cnt;
					OP_CLEAR: do_clr = 1'b1;
					OP_MODIFY: begin
						if (cnt_q == '0) begin
							res_status = ST_EMPTY;
						end else if (!found) begin
							res_status = ST_NOT_FOUND;
						end else begin
							do_del  = 1'b1;
							mod_go  = 1'b1;
							res_vld = 1'b0;
						end
					end
					default: res_status = ST_OK;
				endcase
			end
			BS_RECMP: load_cmp = 1'b1;
			BS_REINS: begin
				do_ins    = 1'b1;
				res_vld   = 1'b1;
				res_match = match_q;
			end
			default: res_vld = 1'b0;
		endcase
	end

	always_comb begin
		cnt_nx = cnt_q;
		if (do_clr) begin
			cnt_nx = '0;
		end else if (do_ins) begin
			cnt_nx = cnt_q + 1'b1;
		end else if (do_del) begin
			cnt_nx = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
			done_q  <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q      <= h_op;
			key_q     <= h_key;
			new_key_q <= h_new_key;
		end
		if (load_cmp) begin
			lt_s1 <= lt_d;
			le_s1 <= le_d;
		end
		if (mod_go) begin
			match_q <= eq_cnt;
		end
		status_q    <= res_status;
		match_out_q <= res_match;
	end

	// cell row: shift right of the insert point, or left over the deleted entry
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins && !lt_s1[i]) begin
				if (i == 0) begin
					cells_q[i] <= ins_key;
				end else begin
					cells_q[i] <= lt_s1[(i > 0) ? i - 1 : 0] ? ins_key
						: cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_del && !lt_s1[i] && (i < CAPACITY - 1)) begin
				cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign match_count = OUT_CNT_W'(match_out_q);
	assign size        = OUT_CNT_W'(cnt_q);

endmodule
`default_nettype wire
